### rtl/core/c2s_pkg.sv
package c2s_pkg;

    // fixed-point formats
    localparam int GUARD_BITS   = 8;
    localparam int TABLE_LEN    = 24;
    localparam int TURN_BITS    = 32;
    localparam int POL_ACC_BITS = 34;
    localparam int KINV_BITS    = 21;
    localparam int KINV_FRAC    = 20;
    localparam int GAIN_SHIFT   = 50;
    localparam int OUT_BITS     = 16;
    localparam int MARGIN_BITS  = 4;

    localparam logic [TURN_BITS-1:0]    HALF_TURN    = 32'h8000_0000;
    localparam logic [POL_ACC_BITS-1:0] QUARTER_TURN = 34'h0_4000_0000;
    localparam logic [OUT_BITS-1:0]     HALF_CODE    = 16'h8000;
    localparam logic [OUT_BITS-1:0]     MAX_CODE     = 16'hFFFF;
    localparam int                      ROUND_HALF   = 32768;
    localparam int                      ANGLE_SHIFT  = 16;

    // atan(2^-i) as fractions of a full turn
    localparam logic [TURN_BITS-1:0] ATAN_TURNS [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // per-point status carried alongside the datapath
    typedef struct packed {
        logic on_axis;
        logic z_neg;
        logic z_zero;
    } c2s_flags_t;

    // number of iterations actually run
    function automatic int step_count(input int steps);
        return (steps < TABLE_LEN) ? steps : TABLE_LEN;
    endfunction

    // square root of the cordic gain product, scaled by 2^30
    function automatic logic [63:0] gain_root(input int n);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bval;
        p = 64'd1 << 60;
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            if (i < n)
            begin
                p = p + (p >> (2 * i));
            end
        end
        v    = p;
        res  = 64'd0;
        bval = 64'd1 << 62;
        for (int j = 0; j < 32; j++)
        begin
            if (bval > v)
            begin
                bval = bval >> 2;
            end
        end
        for (int j = 0; j < 32; j++)
        begin
            if (bval != 64'd0)
            begin
                if (v >= res + bval)
                begin
                    v   = v - (res + bval);
                    res = (res >> 1) + bval;
                end
                else
                begin
                    res = res >> 1;
                end
                bval = bval >> 2;
            end
        end
        if (res == 64'd0)
        begin
            res = 64'd1;
        end
        return res;
    endfunction

endpackage

### rtl/core/cartesian_to_spherical_unit.sv
// Converts a point (x, y, z) to radius, polar angle from +z and azimuth in
// [0, 2pi), angles as fractions of a turn in 16 bits, and flags the zero
// vector on tuser. It takes one point per clock and keeps that rate without
// bubbles while m_tready stays high. A transfer passes through the input
// stage, the two chains of one-iteration CORDIC stages (azimuth pass, then
// polar pass), the gain stage, two output stages and the output register.
// Back-pressure stalls the whole pipeline once the skid slot is full; the
// skid slot catches an item that arrives while the output register waits.
module cartesian_to_spherical_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS   = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    // fields from bit 0: coord_x, coord_y, coord_z, zero fill
    input  logic [((3*COORD_BITS+7)/8)*8-1:0]        s_tdata,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // fields from bit 0: radius, polar_angle, azimuth
    output logic [3*c2s_pkg::OUT_BITS-1:0]           m_tdata,
    // fields from bit 0: zero_vector
    output logic                                     m_tuser,
    output logic                                     m_tvalid,
    input  logic                                     m_tready
);

    localparam int CB     = COORD_BITS;
    localparam int W      = CB + c2s_pkg::GUARD_BITS + c2s_pkg::MARGIN_BITS;
    localparam int NSTEPS = c2s_pkg::step_count(CORDIC_STEPS);
    localparam int FB     = $bits(c2s_pkg::c2s_flags_t);
    localparam int TB     = c2s_pkg::TURN_BITS;
    localparam int PA     = c2s_pkg::POL_ACC_BITS;
    localparam int OB     = c2s_pkg::OUT_BITS;
    localparam int SW1    = CB + FB;
    localparam int SW2    = TB + CB + FB;
    localparam int DW     = 3 * OB + 1;

    logic pipe_en;

    // azimuth pass chain
    logic                p1_valid [0:NSTEPS];
    logic signed [W-1:0] p1_x     [0:NSTEPS];
    logic signed [W-1:0] p1_y     [0:NSTEPS];
    logic [TB-1:0]       p1_acc   [0:NSTEPS];
    logic [SW1-1:0]      p1_side  [0:NSTEPS];
    logic [CB-1:0]       pre_z;
    c2s_pkg::c2s_flags_t pre_flags;

    // polar pass chain
    logic                p2_valid [0:NSTEPS];
    logic signed [W-1:0] p2_x     [0:NSTEPS];
    logic signed [W-1:0] p2_y     [0:NSTEPS];
    logic [PA-1:0]       p2_acc   [0:NSTEPS];
    logic [SW2-1:0]      p2_side  [0:NSTEPS];
    logic [TB-1:0]       g_az;
    logic [CB-1:0]       g_z;
    c2s_pkg::c2s_flags_t g_flags;

    logic                post_valid;
    logic [OB-1:0]       post_radius, post_polar, post_az;
    logic                post_zero;
    logic [DW-1:0]       out_data;

    assign s_tready = pipe_en;

    // input scaling and half-turn fold
    c2s_pre #(
        .CB (CB),
        .W  (W)
    ) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .coord_x   (s_tdata[CB-1:0]),
        .coord_y   (s_tdata[2*CB-1:CB]),
        .coord_z   (s_tdata[3*CB-1:2*CB]),
        .out_valid (p1_valid[0]),
        .out_x     (p1_x[0]),
        .out_y     (p1_y[0]),
        .out_acc   (p1_acc[0]),
        .out_z     (pre_z),
        .out_flags (pre_flags)
    );

    assign p1_side[0] = {pre_z, pre_flags};

    // azimuth pass: one iteration per stage
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_pass1
        c2s_cordic_stage #(
            .W   (W),
            .AW  (TB),
            .IDX (i),
            .SW  (SW1)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (p1_valid[i]),
            .in_x      (p1_x[i]),
            .in_y      (p1_y[i]),
            .in_acc    (p1_acc[i]),
            .in_side   (p1_side[i]),
            .out_valid (p1_valid[i+1]),
            .out_x     (p1_x[i+1]),
            .out_y     (p1_y[i+1]),
            .out_acc   (p1_acc[i+1]),
            .out_side  (p1_side[i+1])
        );
    end

    // inverse gain on the in-plane length, polar pass setup
    c2s_gain #(
        .CB    (CB),
        .W     (W),
        .STEPS (CORDIC_STEPS)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (p1_valid[NSTEPS]),
        .in_x      (p1_x[NSTEPS]),
        .in_acc    (p1_acc[NSTEPS]),
        .in_z      (p1_side[NSTEPS][SW1-1:FB]),
        .in_flags  (c2s_pkg::c2s_flags_t'(p1_side[NSTEPS][FB-1:0])),
        .out_valid (p2_valid[0]),
        .out_x     (p2_x[0]),
        .out_y     (p2_y[0]),
        .out_acc   (p2_acc[0]),
        .out_az    (g_az),
        .out_z     (g_z),
        .out_flags (g_flags)
    );

    assign p2_side[0] = {g_az, g_z, g_flags};

    // polar pass: one iteration per stage
    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_pass2
        c2s_cordic_stage #(
            .W   (W),
            .AW  (PA),
            .IDX (i),
            .SW  (SW2)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (pipe_en),
            .in_valid  (p2_valid[i]),
            .in_x      (p2_x[i]),
            .in_y      (p2_y[i]),
            .in_acc    (p2_acc[i]),
            .in_side   (p2_side[i]),
            .out_valid (p2_valid[i+1]),
            .out_x     (p2_x[i+1]),
            .out_y     (p2_y[i+1]),
            .out_acc   (p2_acc[i+1]),
            .out_side  (p2_side[i+1])
        );
    end

    // radius scaling, angle rounding, on-axis cases
    c2s_post #(
        .CB    (CB),
        .W     (W),
        .STEPS (CORDIC_STEPS)
    ) u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .in_valid    (p2_valid[NSTEPS]),
        .in_x        (p2_x[NSTEPS]),
        .in_pol      ($signed(p2_acc[NSTEPS])),
        .in_az       (p2_side[NSTEPS][SW2-1:CB+FB]),
        .in_z        (p2_side[NSTEPS][CB+FB-1:FB]),
        .in_flags    (c2s_pkg::c2s_flags_t'(p2_side[NSTEPS][FB-1:0])),
        .out_valid   (post_valid),
        .radius      (post_radius),
        .polar_angle (post_polar),
        .azimuth     (post_az),
        .zero_vector (post_zero)
    );

    // output register and skid slot
    c2s_out_buf #(
        .DW (DW)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (post_valid),
        .in_data   ({post_zero, post_az, post_polar, post_radius}),
        .pipe_en   (pipe_en),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data[3*OB-1:0];
    assign m_tuser = out_data[DW-1];

endmodule

### rtl/core/c2s_pre.sv
module c2s_pre #(
    parameter int CB = 16,
    parameter int W  = 28
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [CB-1:0]                    coord_x,
    input  logic [CB-1:0]                    coord_y,
    input  logic [CB-1:0]                    coord_z,
    output logic                             out_valid,
    output logic signed [W-1:0]              out_x,
    output logic signed [W-1:0]              out_y,
    output logic [c2s_pkg::TURN_BITS-1:0]    out_acc,
    output logic [CB-1:0]                    out_z,
    output c2s_pkg::c2s_flags_t              out_flags
);

    logic                          valid_reg;
    logic signed [W-1:0]           x_reg, x_next;
    logic signed [W-1:0]           y_reg, y_next;
    logic [c2s_pkg::TURN_BITS-1:0] acc_reg, acc_next;
    logic [CB-1:0]                 z_reg;
    c2s_pkg::c2s_flags_t           flags_reg, flags_next;
    logic signed [W-1:0]           xs, ys;

    // scale into the guarded datapath, fold negative x by a half turn
    always_comb
    begin
        xs = W'($signed(coord_x)) <<< c2s_pkg::GUARD_BITS;
        ys = W'($signed(coord_y)) <<< c2s_pkg::GUARD_BITS;
        if (coord_x[CB-1])
        begin
            x_next   = -xs;
            y_next   = -ys;
            acc_next = c2s_pkg::HALF_TURN;
        end
        else
        begin
            x_next   = xs;
            y_next   = ys;
            acc_next = '0;
        end
        flags_next.on_axis = (coord_x == '0) && (coord_y == '0);
        flags_next.z_neg   = coord_z[CB-1];
        flags_next.z_zero  = (coord_z == '0);
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            z_reg     <= coord_z;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_z     = z_reg;
    assign out_flags = flags_reg;

endmodule

### rtl/core/c2s_cordic_stage.sv
module c2s_cordic_stage #(
    parameter int W   = 28,
    parameter int AW  = 32,
    parameter int IDX = 0,
    parameter int SW  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [W-1:0] in_x,
    input  logic signed [W-1:0] in_y,
    input  logic [AW-1:0]       in_acc,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic signed [W-1:0] out_x,
    output logic signed [W-1:0] out_y,
    output logic [AW-1:0]       out_acc,
    output logic [SW-1:0]       out_side
);

    localparam logic [AW-1:0] ATAN = AW'(c2s_pkg::ATAN_TURNS[IDX]);

    logic                valid_reg;
    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [SW-1:0]       side_reg;
    logic signed [W-1:0] dx, dy;
    logic                y_pos;

    // one vectoring iteration: drive y toward zero
    always_comb
    begin
        dx    = in_y >>> IDX;
        dy    = in_x >>> IDX;
        y_pos = !in_y[W-1] && (in_y != '0);
        if (y_pos)
        begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            acc_next = in_acc + ATAN;
        end
        else
        begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            acc_next = in_acc - ATAN;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = acc_reg;
    assign out_side  = side_reg;

endmodule

### rtl/core/c2s_gain.sv
module c2s_gain #(
    parameter int CB    = 16,
    parameter int W     = 28,
    parameter int STEPS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [W-1:0]               in_x,
    input  logic [c2s_pkg::TURN_BITS-1:0]     in_acc,
    input  logic [CB-1:0]                     in_z,
    input  c2s_pkg::c2s_flags_t               in_flags,
    output logic                              out_valid,
    output logic signed [W-1:0]               out_x,
    output logic signed [W-1:0]               out_y,
    output logic [c2s_pkg::POL_ACC_BITS-1:0]  out_acc,
    output logic [c2s_pkg::TURN_BITS-1:0]     out_az,
    output logic [CB-1:0]                     out_z,
    output c2s_pkg::c2s_flags_t               out_flags
);

    localparam int          KB        = c2s_pkg::KINV_BITS;
    localparam int          PW        = W + KB;
    localparam logic [63:0] KINV_FULL = (64'd1 << c2s_pkg::GAIN_SHIFT) /
                                        c2s_pkg::gain_root(c2s_pkg::step_count(STEPS));
    localparam logic [KB-1:0] KINV    = KINV_FULL[KB-1:0];

    logic                          valid_reg;
    logic signed [W-1:0]           x_reg, y_reg;
    logic signed [W-1:0]           y_next;
    logic [c2s_pkg::TURN_BITS-1:0] az_reg;
    logic [CB-1:0]                 z_reg;
    c2s_pkg::c2s_flags_t           flags_reg;
    logic [PW-1:0]                 prod;
    logic signed [W-1:0]           x_next;

    // in-plane length times inverse gain; second pass starts on (r_xy, -z)
    always_comb
    begin
        prod   = PW'(unsigned'(in_x)) * PW'(KINV);
        x_next = $signed(prod[c2s_pkg::KINV_FRAC +: W]);
        y_next = -(W'($signed(in_z)) <<< c2s_pkg::GUARD_BITS);
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            az_reg    <= in_acc;
            z_reg     <= in_z;
            flags_reg <= in_flags;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_acc   = c2s_pkg::QUARTER_TURN;
    assign out_az    = az_reg;
    assign out_z     = z_reg;
    assign out_flags = flags_reg;

endmodule

### rtl/core/c2s_post.sv
module c2s_post #(
    parameter int CB    = 16,
    parameter int W     = 28,
    parameter int STEPS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic signed [W-1:0]                     in_x,
    input  logic signed [c2s_pkg::POL_ACC_BITS-1:0] in_pol,
    input  logic [c2s_pkg::TURN_BITS-1:0]           in_az,
    input  logic [CB-1:0]                           in_z,
    input  c2s_pkg::c2s_flags_t                     in_flags,
    output logic                                    out_valid,
    output logic [c2s_pkg::OUT_BITS-1:0]            radius,
    output logic [c2s_pkg::OUT_BITS-1:0]            polar_angle,
    output logic [c2s_pkg::OUT_BITS-1:0]            azimuth,
    output logic                                    zero_vector
);

    localparam int          KB        = c2s_pkg::KINV_BITS;
    localparam int          PW        = W + KB;
    localparam int          SH        = c2s_pkg::KINV_FRAC + c2s_pkg::GUARD_BITS;
    localparam int          RW        = PW - SH;
    localparam int          PA        = c2s_pkg::POL_ACC_BITS;
    localparam int          OB        = c2s_pkg::OUT_BITS;
    localparam logic [63:0] KINV_FULL = (64'd1 << c2s_pkg::GAIN_SHIFT) /
                                        c2s_pkg::gain_root(c2s_pkg::step_count(STEPS));
    localparam logic [KB-1:0] KINV    = KINV_FULL[KB-1:0];
    localparam logic signed [PA-1:0] POL_MAX = PA'(c2s_pkg::ROUND_HALF);

    // stage a: radius product and angle rounding
    logic                valid_a_reg;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [OB-1:0]       pol_reg, pol_next;
    logic [OB-1:0]       az_reg, az_next;
    logic [CB-1:0]       z_reg;
    c2s_pkg::c2s_flags_t flags_reg;
    logic [W-1:0]        ux;
    logic signed [PA-1:0] pol_sum, pol_shift;
    logic [c2s_pkg::TURN_BITS-1:0] az_sum;

    always_comb
    begin
        ux        = in_x[W-1] ? '0 : unsigned'(in_x);
        prod_next = PW'(ux) * PW'(KINV);
        pol_sum   = in_pol + PA'(c2s_pkg::ROUND_HALF);
        pol_shift = pol_sum >>> c2s_pkg::ANGLE_SHIFT;
        if (pol_shift[PA-1])
        begin
            pol_next = '0;
        end
        else if (pol_shift > POL_MAX)
        begin
            pol_next = c2s_pkg::HALF_CODE;
        end
        else
        begin
            pol_next = pol_shift[OB-1:0];
        end
        az_sum  = in_az + c2s_pkg::TURN_BITS'(c2s_pkg::ROUND_HALF);
        az_next = az_sum[c2s_pkg::TURN_BITS-1 -: OB];
    end

    // stage b: saturation and on-axis selection
    logic          valid_b_reg;
    logic [OB-1:0] rad_b_reg, rad_b_next;
    logic [OB-1:0] pol_b_reg, pol_b_next;
    logic [OB-1:0] az_b_reg, az_b_next;
    logic          zero_b_reg, zero_b_next;
    logic [RW-1:0] rad_full;
    logic [63:0]   rad64;
    logic [CB:0]   zmag;
    logic [63:0]   zmag64;

    always_comb
    begin
        rad_full = prod_reg[PW-1:SH];
        rad64    = 64'(rad_full);
        zmag     = flags_reg.z_neg ? unsigned'(-{z_reg[CB-1], z_reg}) : {z_reg[CB-1], z_reg};
        zmag64   = 64'(zmag);
        if (flags_reg.on_axis)
        begin
            rad_b_next  = (zmag64 > 64'(c2s_pkg::MAX_CODE)) ? c2s_pkg::MAX_CODE : zmag64[OB-1:0];
            pol_b_next  = flags_reg.z_neg ? c2s_pkg::HALF_CODE : '0;
            az_b_next   = '0;
            zero_b_next = flags_reg.z_zero;
        end
        else
        begin
            rad_b_next  = (rad64 > 64'(c2s_pkg::MAX_CODE)) ? c2s_pkg::MAX_CODE : rad64[OB-1:0];
            pol_b_next  = pol_reg;
            az_b_next   = az_reg;
            zero_b_next = 1'b0;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            pol_reg    <= pol_next;
            az_reg     <= az_next;
            z_reg      <= in_z;
            flags_reg  <= in_flags;
            rad_b_reg  <= rad_b_next;
            pol_b_reg  <= pol_b_next;
            az_b_reg   <= az_b_next;
            zero_b_reg <= zero_b_next;
        end
    end

    assign out_valid   = valid_b_reg;
    assign radius      = rad_b_reg;
    assign polar_angle = pol_b_reg;
    assign azimuth     = az_b_reg;
    assign zero_vector = zero_b_reg;

endmodule

### rtl/core/c2s_out_buf.sv
module c2s_out_buf #(
    parameter int DW = 49
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          pipe_en,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic [DW-1:0] out_data_reg, out_data_next;
    logic [DW-1:0] skid_data_reg, skid_data_next;
    logic          pop, push;

    // the pipeline moves whenever the skid slot is free
    assign pipe_en = !skid_valid_reg;
    assign pop     = out_valid_reg && out_ready;
    assign push    = pipe_en && in_valid;

    // output register plus one skid slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### bench/tb_top.sv
module tb_top;

    localparam int OUT_BITS    = c2s_pkg::OUT_BITS;
    localparam int STEPS       = 16;
    localparam int COORD_W     = 16;
    localparam int IN_W        = ((3*COORD_W+7)/8)*8;
    localparam int GUARD       = 8;
    localparam int KINV_FRAC   = 20;
    localparam int LATENCY     = 2*STEPS+5;
    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 12;

    localparam logic signed [63:0] HALF_TURN_ACC    = 64'sd2147483648;
    localparam logic signed [63:0] QUARTER_TURN_ACC = 64'sd1073741824;
    localparam logic [OUT_BITS-1:0] POLAR_PI        = 16'h8000;
    localparam logic [OUT_BITS-1:0] RADIUS_SAT      = 16'hFFFF;

    // one point as it travels on s_tdata, x in the low bits
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] radius;
        logic [OUT_BITS-1:0] polar_angle;
        logic [OUT_BITS-1:0] azimuth;
        logic                zero_vector;
    } sphere_t;

    // length and turned angle left by one vectoring pass
    typedef struct packed {
        logic signed [63:0] mag;
        logic signed [63:0] angle;
    } pass_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic [IN_W-1:0]       s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [3*OUT_BITS-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    point_t  points_to_send [$];
    sphere_t spherical_due  [$];
    logic [63:0] inv_gain;
    sphere_t want;
    point_t  sent_point;
    int idle_pct     = IDLE_PCT;
    int errors       = 0;
    int sent_count   = 0;
    int axis_count   = 0;
    int zero_count   = 0;
    int result_count = 0;
    int cycle_count  = 0;

    cartesian_to_spherical_unit #(
        .CORDIC_STEPS(STEPS),
        .COORD_BITS  (COORD_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    always #5 clk = ~clk;

    // atan(2^-i) in 32-bit fractions of a turn
    function automatic longint atan_turn(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            default: return 81;
        endcase
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // 1/K in Q20 from the product of (1 + 4^-i)
    function automatic logic [63:0] inverse_gain();
        logic [63:0] p;
        logic [63:0] k;
        p = 64'd1 << 60;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            p = p + (p >> (2 * i));
        end
        k = root_floor(p);
        if (k == 64'd0)
        begin
            k = 64'd1;
        end
        return (64'd1 << 50) / k;
    endfunction

    // drive vy toward zero, collect the angle turned
    function automatic pass_t vector_pass(input logic signed [63:0] vx,
                                          input logic signed [63:0] vy);
        pass_t r;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic signed [63:0] acc;
        acc = 64'sd0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + atan_turn(i);
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - atan_turn(i);
            end
        end
        r.mag   = vx;
        r.angle = acc;
        return r;
    endfunction

    // radius, polar angle and azimuth of one point
    function automatic sphere_t spherical_of(input point_t p);
        sphere_t r;
        pass_t   first;
        pass_t   second;
        logic signed [63:0] vx;
        logic signed [63:0] vy;
        logic signed [63:0] vz;
        logic signed [63:0] az_acc;
        logic signed [63:0] pol_acc;
        logic signed [63:0] pol;
        logic signed [63:0] mag;
        logic signed [63:0] plane;
        logic [63:0] rad;
        logic [63:0] az_sum;
        r  = '0;
        vx = {{(64-COORD_W){p.x[COORD_W-1]}}, p.x};
        vy = {{(64-COORD_W){p.y[COORD_W-1]}}, p.y};
        vz = {{(64-COORD_W){p.z[COORD_W-1]}}, p.z};
        if (vx == 0 && vy == 0)
        begin
            // on the z axis, cordic bypassed
            mag = (vz < 0) ? -vz : vz;
            r.radius      = mag[OUT_BITS-1:0];
            r.polar_angle = (vz < 0) ? POLAR_PI : '0;
            r.azimuth     = '0;
            r.zero_vector = (vz == 0);
        end
        else
        begin
            vx = vx <<< GUARD;
            vy = vy <<< GUARD;
            vz = vz <<< GUARD;
            az_acc = 64'sd0;
            // left half plane: turn by half a turn first
            if (vx < 0)
            begin
                vx     = -vx;
                vy     = -vy;
                az_acc = HALF_TURN_ACC;
            end
            first  = vector_pass(vx, vy);
            mag    = first.mag;
            az_acc = az_acc + first.angle;
            plane  = $signed(($unsigned(mag) * inv_gain) >> KINV_FRAC);
            second = vector_pass(plane, -vz);
            mag    = second.mag;
            pol_acc = QUARTER_TURN_ACC + second.angle;
            if (mag < 0)
            begin
                rad = 64'd0;
            end
            else
            begin
                rad = ($unsigned(mag) * inv_gain) >> (KINV_FRAC + GUARD);
            end
            az_sum = {32'd0, az_acc[31:0]} + 64'd32768;
            pol    = (pol_acc + 64'sd32768) >>> 16;
            if (pol < 0)
            begin
                pol = 64'sd0;
            end
            if (pol > 32768)
            begin
                pol = 64'sd32768;
            end
            r.radius      = (rad > 64'd65535) ? RADIUS_SAT : rad[OUT_BITS-1:0];
            r.polar_angle = pol[OUT_BITS-1:0];
            r.azimuth     = az_sum[31:16];
            r.zero_vector = 1'b0;
        end
        return r;
    endfunction

    function automatic point_t point_of(input int x, input int y, input int z);
        point_t p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.z = z[COORD_W-1:0];
        return p;
    endfunction

    function automatic int corner_value();
        case ($urandom_range(6))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            default: return 32767;
        endcase
    endfunction

    function automatic int near_zero();
        return int'($urandom_range(127)) - 64;
    endfunction

    // mix of full-range points, small ones, axes, corners and left-half-plane points
    function automatic point_t random_point();
        point_t p;
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            p = point_of($urandom, $urandom, $urandom);
        end
        else if (pick < 60)
        begin
            p = point_of(near_zero(), near_zero(), near_zero());
        end
        else if (pick < 70)
        begin
            p = point_of(0, 0, $urandom);
        end
        else if (pick < 72)
        begin
            p = point_of(0, 0, 0);
        end
        else if (pick < 84)
        begin
            p = point_of(corner_value(), corner_value(), corner_value());
        end
        else if (pick < 92)
        begin
            p = point_of(-int'($urandom_range(32768, 16384)), near_zero(), $urandom);
        end
        else if (pick < 96)
        begin
            p = point_of(0, $urandom, $urandom);
        end
        else
        begin
            p = point_of($urandom, 0, $urandom);
        end
        return p;
    endfunction

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            points_to_send.push_back(random_point());
        end
    endtask

    task automatic wait_drained();
        while (points_to_send.size() != 0 || s_tvalid || spherical_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sender: predict on each transfer, then offer the next point
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sent_point = s_tdata;
                spherical_due.push_back(spherical_of(sent_point));
                sent_count++;
                if (sent_point.x == 0 && sent_point.y == 0)
                begin
                    axis_count++;
                    if (sent_point.z == 0)
                    begin
                        zero_count++;
                    end
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (points_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    s_tdata  <= points_to_send.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each transfer against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (spherical_due.size() == 0)
                begin
                    $error("result transfer with no point outstanding: tdata %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = spherical_due.pop_front();
                    if (m_tdata[15:0] !== want.radius)
                    begin
                        $error("radius: expected %0d, actual %0d", want.radius,
                               m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[31:16] !== want.polar_angle)
                    begin
                        $error("polar_angle: expected %0d, actual %0d", want.polar_angle,
                               m_tdata[31:16]);
                        errors++;
                    end
                    if (m_tdata[47:32] !== want.azimuth)
                    begin
                        $error("azimuth: expected %0d, actual %0d", want.azimuth,
                               m_tdata[47:32]);
                        errors++;
                    end
                    if (m_tuser !== want.zero_vector)
                    begin
                        $error("zero_vector: expected %0d, actual %0d", want.zero_vector,
                               m_tuser);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     spherical_due.size());
            $display("cartesian_to_spherical_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        inv_gain = inverse_gain();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // zero vector and the z axis
        points_to_send.push_back(point_of(0, 0, 0));
        points_to_send.push_back(point_of(0, 0, 32767));
        points_to_send.push_back(point_of(0, 0, -32768));
        points_to_send.push_back(point_of(0, 0, 1));
        points_to_send.push_back(point_of(0, 0, -1));
        // x and y axes, both signs
        points_to_send.push_back(point_of(32767, 0, 0));
        points_to_send.push_back(point_of(-32768, 0, 0));
        points_to_send.push_back(point_of(0, 32767, 0));
        points_to_send.push_back(point_of(0, -32768, 0));
        points_to_send.push_back(point_of(-1, 0, 0));
        points_to_send.push_back(point_of(1, 0, 0));
        // largest radius, some corners
        points_to_send.push_back(point_of(32767, 32767, 32767));
        points_to_send.push_back(point_of(-32768, -32768, -32768));
        points_to_send.push_back(point_of(-32768, 32767, -32768));
        // azimuth just under a full turn wraps to zero
        points_to_send.push_back(point_of(32767, -1, 0));
        // either side of the negative x axis
        points_to_send.push_back(point_of(-32768, 1, 5));
        points_to_send.push_back(point_of(-32768, -1, -5));
        // polar angle close to 0 and to pi
        points_to_send.push_back(point_of(1, 0, 32767));
        points_to_send.push_back(point_of(1, 0, -32768));
        points_to_send.push_back(point_of(0, -1, -32768));
        // diagonals and tiny points
        points_to_send.push_back(point_of(1, -1, 0));
        points_to_send.push_back(point_of(-1, -1, 1));
        points_to_send.push_back(point_of(12345, -23456, 7890));

        // no new points are queued until the pipeline is empty
        wait_drained();

        queue_random(500);
        wait_drained();

        // long stretch with no idling on either side
        idle_pct = 0;
        queue_random(300);
        wait_drained();
        idle_pct = IDLE_PCT;

        queue_random(500);
        wait_drained();

        repeat (4 * LATENCY) @(posedge clk);
        if (spherical_due.size() != 0)
        begin
            $error("%0d predicted results never arrived", spherical_due.size());
            errors++;
        end

        $display("%0d points converted and checked, %0d on the z axis, %0d zero vectors,",
                 sent_count, axis_count, zero_count);
        $display("with corner, left-half-plane and full-range points under random stalls");
        if (errors == 0)
        begin
            $display("cartesian_to_spherical_unit regression: pass");
        end
        else
        begin
            $display("cartesian_to_spherical_unit regression: fail");
        end
        $finish;
    end

endmodule
